>>> hdl/orfpe_pkg.sv
// Shared types and constants of the pulse-width OOK remote frame encoder.
// Used by the front end, the sequencer and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package orfpe_pkg;

   localparam int FRAME_BITS    = 65;
   localparam int PAYLOAD_BITS  = 64;
   localparam logic [7:0] START_BYTE = 8'hA3;

   localparam int TICKS_W       = 20;
   localparam int POS_W         = 7;
   localparam int RSP_DEPTH     = 2;

   // Configuration register indexes
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 24;
   localparam logic [CSR_INDEX_W-1:0] CSR_REMOTE_ID    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPEAT_COUNT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_AGC_HIGH     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_AGC_LOW      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_PULSE   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHORT_PULSE  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_SILENCE      = 3'd6;

   typedef struct packed {
      logic        req_type;
      logic [15:0] channel;
      logic [7:0]  command;
   } req_item_type;

   typedef struct packed {
      logic line_level;
      logic busy_res;
      logic accepted;
      logic done_res;
   } rsp_item_type;

   // Classified item handed from the front to the sequencer
   typedef struct packed {
      logic                    is_start;
      logic [PAYLOAD_BITS-1:0] frame;
   } work_item_type;

   // Timing registers seen by the sequencer
   typedef struct packed {
      logic [7:0]         repeat_count;
      logic [15:0]        agc_high_ticks;
      logic [15:0]        agc_low_ticks;
      logic [15:0]        long_pulse_ticks;
      logic [15:0]        short_pulse_ticks;
      logic [TICKS_W-1:0] silence_ticks;
   } cfg_type;

endpackage

`default_nettype wire

>>> hdl/orfpe_queue.sv
// Small first-in first-out queue of flip-flops, generic in item type and depth.
// Depends on nothing; used between front and sequencer and on the result side.
`timescale 1ns / 1ps
`default_nettype none

module orfpe_queue #(
   parameter type item_type = logic,
   parameter int  DEPTH     = 2
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type push_data,
   output logic          full,
   input  wire logic     pop,
   output item_type      pop_data,
   output logic          empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type         mem_ff [DEPTH];
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> hdl/orfpe_front.sv
// Front end: classifies incoming items and builds the frame and checksum of a start.
// Depends on orfpe_pkg; feeds the work queue.
`timescale 1ns / 1ps
`default_nettype none

module orfpe_front
   import orfpe_pkg::*;
(
   input  wire req_item_type req_item,
   input  wire logic [23:0] remote_id,
   output work_item_type work_item
);

   logic [7:0] checksum;

   // Byte sum wraps at 8 bits
   assign checksum = remote_id[23:16] + remote_id[15:8] + remote_id[7:0]
                   + req_item.channel[15:8] + req_item.channel[7:0] + req_item.command;

   assign work_item.is_start = req_item.req_type;
   assign work_item.frame    = {START_BYTE, remote_id, req_item.channel,
                                req_item.command, checksum};

endmodule

`default_nettype wire

>>> hdl/orfpe_back.sv
// Back end: the segment sequencer that turns ticks into the line waveform.
// Depends on orfpe_pkg; pops the work queue and pushes results.
`timescale 1ns / 1ps
`default_nettype none

module orfpe_back
   import orfpe_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    work_valid,
   input  wire work_item_type work_item,
   output logic         work_pop,
   input  wire logic    rsp_room,
   output logic         rsp_push,
   output rsp_item_type rsp_item
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_AGC_HIGH,
      PH_AGC_LOW,
      PH_BIT_HIGH,
      PH_BIT_LOW,
      PH_SILENCE
   } phase_type;

   phase_type               phase_ff, phase_in;
   logic [POS_W-1:0]        bit_pos_ff, bit_pos_in;
   logic [TICKS_W-1:0]      ticks_ff, ticks_in;
   logic [7:0]              repeats_ff, repeats_in;
   logic [PAYLOAD_BITS-1:0] payload_ff, payload_in;
   logic                    settling_ff, settling_in;
   logic                    hold_start_ff, hold_start_in;
   logic                    hold_acc_ff, hold_acc_in;
   logic                    hold_level_ff, hold_level_in;

   phase_type               adv_phase;
   logic [POS_W-1:0]        adv_pos, pos_inc;
   logic [TICKS_W-1:0]      adv_ticks;
   logic [7:0]              adv_repeats, rep_dec;

   phase_type               item_phase;
   logic [POS_W-1:0]        item_pos;
   logic [TICKS_W-1:0]      item_ticks, ticks_dec;
   logic [7:0]              item_repeats;
   logic [PAYLOAD_BITS-1:0] item_payload;
   logic                    item_settle, settle_done;

   function automatic logic bit_at(input logic [POS_W-1:0] pos,
                                   input logic [PAYLOAD_BITS-1:0] frame);
      // Positions past the payload carry the trailing one
      return pos[POS_W-1] ? 1'b1 : frame[~pos[5:0]];
   endfunction

   function automatic logic level_of(input phase_type ph);
      return (ph == PH_AGC_HIGH) || (ph == PH_BIT_HIGH);
   endfunction

   // One segment step from the current registers
   always_comb begin
      adv_phase   = PH_IDLE;
      adv_pos     = bit_pos_ff;
      adv_ticks   = '0;
      adv_repeats = repeats_ff;
      pos_inc     = bit_pos_ff + 1'b1;
      rep_dec     = repeats_ff - 1'b1;
      case (phase_ff)
         PH_AGC_HIGH: begin
            adv_phase = PH_AGC_LOW;
            adv_ticks = TICKS_W'(cfg.agc_low_ticks);
         end
         PH_AGC_LOW: begin
            adv_phase = PH_BIT_HIGH;
            adv_pos   = '0;
            adv_ticks = payload_ff[PAYLOAD_BITS-1] ? TICKS_W'(cfg.long_pulse_ticks)
                                                   : TICKS_W'(cfg.short_pulse_ticks);
         end
         PH_BIT_HIGH: begin
            adv_phase = PH_BIT_LOW;
            adv_ticks = bit_at(bit_pos_ff, payload_ff) ? TICKS_W'(cfg.short_pulse_ticks)
                                                       : TICKS_W'(cfg.long_pulse_ticks);
         end
         PH_BIT_LOW: begin
            adv_pos = pos_inc;
            if (pos_inc < POS_W'(FRAME_BITS)) begin
               adv_phase = PH_BIT_HIGH;
               adv_ticks = bit_at(pos_inc, payload_ff) ? TICKS_W'(cfg.long_pulse_ticks)
                                                       : TICKS_W'(cfg.short_pulse_ticks);
            end else begin
               adv_phase = PH_SILENCE;
               adv_ticks = cfg.silence_ticks;
            end
         end
         PH_SILENCE: begin
            adv_repeats = rep_dec;
            adv_pos     = '0;
            if (rep_dec != '0) begin
               adv_phase = PH_AGC_HIGH;
               adv_ticks = TICKS_W'(cfg.agc_high_ticks);
            end
         end
         default: begin
            adv_phase = PH_IDLE;
         end
      endcase
   end

   // Effect of the item at the head of the work queue
   always_comb begin
      item_phase   = phase_ff;
      item_pos     = bit_pos_ff;
      item_ticks   = ticks_ff;
      item_repeats = repeats_ff;
      item_payload = payload_ff;
      ticks_dec    = ticks_ff - 1'b1;
      if (work_item.is_start) begin
         if (phase_ff == PH_IDLE) begin
            item_payload = work_item.frame;
            item_pos     = '0;
            item_repeats = cfg.repeat_count;
            if (cfg.repeat_count != '0) begin
               item_phase = PH_AGC_HIGH;
               item_ticks = TICKS_W'(cfg.agc_high_ticks);
            end else begin
               item_ticks = '0;
            end
         end
      end else if (phase_ff != PH_IDLE) begin
         if (ticks_dec == '0) begin
            item_phase   = adv_phase;
            item_pos     = adv_pos;
            item_ticks   = adv_ticks;
            item_repeats = adv_repeats;
         end else begin
            item_ticks = ticks_dec;
         end
      end
      item_settle = (item_phase != PH_IDLE) && (item_ticks == '0);
   end

   assign settle_done = (phase_ff == PH_IDLE) || (ticks_ff != '0);
   assign work_pop    = rsp_room && !settling_ff && work_valid;

   always_comb begin
      phase_in      = phase_ff;
      bit_pos_in    = bit_pos_ff;
      ticks_in      = ticks_ff;
      repeats_in    = repeats_ff;
      payload_in    = payload_ff;
      settling_in   = settling_ff;
      hold_start_in = hold_start_ff;
      hold_acc_in   = hold_acc_ff;
      hold_level_in = hold_level_ff;
      rsp_push      = 1'b0;
      rsp_item      = '0;
      if (rsp_room) begin
         if (settling_ff) begin
            if (settle_done) begin
               settling_in         = 1'b0;
               rsp_push            = 1'b1;
               rsp_item.line_level = hold_start_ff ? level_of(phase_ff) : hold_level_ff;
               rsp_item.busy_res   = (phase_ff != PH_IDLE);
               rsp_item.accepted   = hold_acc_ff;
               rsp_item.done_res   = !hold_start_ff && (phase_ff == PH_IDLE);
            end else begin
               // skip a zero-length segment
               phase_in   = adv_phase;
               bit_pos_in = adv_pos;
               ticks_in   = adv_ticks;
               repeats_in = adv_repeats;
            end
         end else if (work_valid) begin
            phase_in      = item_phase;
            bit_pos_in    = item_pos;
            ticks_in      = item_ticks;
            repeats_in    = item_repeats;
            payload_in    = item_payload;
            settling_in   = item_settle;
            hold_start_in = work_item.is_start;
            hold_acc_in   = work_item.is_start && (phase_ff == PH_IDLE);
            hold_level_in = level_of(phase_ff);
            rsp_push      = !item_settle;
            rsp_item.line_level = work_item.is_start ? level_of(item_phase)
                                                     : level_of(phase_ff);
            rsp_item.busy_res   = (item_phase != PH_IDLE);
            rsp_item.accepted   = work_item.is_start && (phase_ff == PH_IDLE);
            rsp_item.done_res   = !work_item.is_start && (phase_ff != PH_IDLE)
                                  && (item_phase == PH_IDLE);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         bit_pos_ff  <= '0;
         ticks_ff    <= '0;
         repeats_ff  <= '0;
         settling_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         bit_pos_ff  <= bit_pos_in;
         ticks_ff    <= ticks_in;
         repeats_ff  <= repeats_in;
         settling_ff <= settling_in;
      end
      payload_ff    <= payload_in;
      hold_start_ff <= hold_start_in;
      hold_acc_ff   <= hold_acc_in;
      hold_level_ff <= hold_level_in;
   end

endmodule

`default_nettype wire

>>> hdl/ook_remote_frame_pulse_encoder_unit.sv
// Pulse-width OOK remote frame encoder, top level.
// Holds the configuration registers; depends on orfpe_pkg, orfpe_queue,
// orfpe_front and orfpe_back.
//
// Input items enter on push/full with req_item: a tick advances the line
// waveform by one time unit, a start loads channel and command and builds
// a 65-bit frame (start byte, remote id, channel, command, checksum, one).
// Each item yields one result on empty/pop with rsp_item: line level,
// busy, start accepted and end of the last repeat.
// Timing registers are written on csr_valid/csr_ready (always ready); the
// user must write them only while the block is idle, which it does not enforce.
// One item is taken per cycle while the result queue has room and no
// segment skip is pending; an item that lands on zero-length segments
// holds the sequencer while the single segment-step unit skips them.
// A work queue separates the front end from the sequencer, and a two-entry
// result queue lets input keep flowing while a result waits; when pop
// stays low both queues fill and full rises.
// Reset empties both queues, stops any transmission and loads the register
// defaults (id 0, one repeat, 5300/530/600/300 ticks, 10000 silence).
`timescale 1ns / 1ps
`default_nettype none

module ook_remote_frame_pulse_encoder_unit
   import orfpe_pkg::*;
#(
   parameter int WORK_DEPTH = 2
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire req_item_type           req_item,
   output logic                        full,
   input  wire logic                   pop,
   output rsp_item_type                rsp_item,
   output logic                        empty,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   logic [23:0]        remote_id_ff;
   logic [7:0]         repeat_count_ff;
   logic [15:0]        agc_high_ff, agc_low_ff, long_pulse_ff, short_pulse_ff;
   logic [TICKS_W-1:0] silence_ff;

   cfg_type       cfg;
   work_item_type front_item, head_item;
   rsp_item_type  back_rsp;
   logic          work_empty, work_pop;
   logic          rsp_full, rsp_push;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         remote_id_ff    <= 24'd0;
         repeat_count_ff <= 8'd1;
         agc_high_ff     <= 16'd5300;
         agc_low_ff      <= 16'd530;
         long_pulse_ff   <= 16'd600;
         short_pulse_ff  <= 16'd300;
         silence_ff      <= 20'd10000;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_REMOTE_ID:    remote_id_ff    <= csr_data[23:0];
            CSR_REPEAT_COUNT: repeat_count_ff <= csr_data[7:0];
            CSR_AGC_HIGH:     agc_high_ff     <= csr_data[15:0];
            CSR_AGC_LOW:      agc_low_ff      <= csr_data[15:0];
            CSR_LONG_PULSE:   long_pulse_ff   <= csr_data[15:0];
            CSR_SHORT_PULSE:  short_pulse_ff  <= csr_data[15:0];
            CSR_SILENCE:      silence_ff      <= csr_data[TICKS_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.repeat_count      = repeat_count_ff;
   assign cfg.agc_high_ticks    = agc_high_ff;
   assign cfg.agc_low_ticks     = agc_low_ff;
   assign cfg.long_pulse_ticks  = long_pulse_ff;
   assign cfg.short_pulse_ticks = short_pulse_ff;
   assign cfg.silence_ticks     = silence_ff;

   orfpe_front u_front (
      .req_item  (req_item),
      .remote_id (remote_id_ff),
      .work_item (front_item)
   );

   orfpe_queue #(
      .item_type (work_item_type),
      .DEPTH     (WORK_DEPTH)
   ) u_work_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_item),
      .full      (full),
      .pop       (work_pop),
      .pop_data  (head_item),
      .empty     (work_empty)
   );

   orfpe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .work_valid (!work_empty),
      .work_item  (head_item),
      .work_pop   (work_pop),
      .rsp_room   (!rsp_full),
      .rsp_push   (rsp_push),
      .rsp_item   (back_rsp)
   );

   orfpe_queue #(
      .item_type (rsp_item_type),
      .DEPTH     (RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (back_rsp),
      .full      (rsp_full),
      .pop       (pop),
      .pop_data  (rsp_item),
      .empty     (empty)
   );

endmodule

`default_nettype wire
